[hw/rtl/lbg_pkg.sv]
// Package for the LED bar-graph renderer: payload structs, controller/datapath
// interface structs, constants and small encode/saturate helpers.
// Depends on nothing; every other file in hw/rtl uses it by scoped names.
package lbg_pkg;

    // LED index width, fixed by the strip addressing
    localparam int LED_W = 6;
    // Run length width: holds 0 through 64
    localparam int RUN_W = 7;
    // Percent values after saturation fit in 7 bits
    localparam int PCT_W = 7;
    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    // floor(x / 100) == (x * 5243) >> 19 for every x below 43690
    localparam int RECIP_W = 13;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int RECIP_SHIFT = 19;

    // Product widths: channel * brightness <= 25500, level * span <= 6300
    localparam int CPROD_W = 15;
    localparam int HPROD_W = 13;

    // WS2812 SPI symbols, three SPI bits per data bit
    localparam logic [2:0] SYM_ONE  = 3'b110;
    localparam logic [2:0] SYM_ZERO = 3'b100;

    // Operation codes
    localparam logic OP_FILL   = 1'b0;
    localparam logic OP_MARKER = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_LED  = 1'b1;

    // One bar command
    typedef struct packed {
        logic       operation;
        logic [7:0] level_percent;
        logic [7:0] brightness_percent;
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
        logic [6:0] marker_size;
    } cmd_t;

    // One LED write
    typedef struct packed {
        logic [LED_W-1:0] led_index;
        logic [23:0]      encoded_red;
        logic [23:0]      encoded_green;
        logic [23:0]      encoded_blue;
        logic             last_of_run;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic mul;
        logic div;
        logic setup;
        logic step;
    } ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic run_empty;
        logic run_last;
    } sts_t;

    // Saturate an 8-bit percent to 100
    function automatic logic [PCT_W-1:0] sat_pct(input logic [7:0] v);
        logic [PCT_W-1:0] r;
        r = (v > 8'(PCT_MAX)) ? PCT_MAX : v[PCT_W-1:0];
        return r;
    endfunction

    // Expand each data bit into its three-bit SPI symbol, bit i at [3i+2:3i]
    function automatic logic [23:0] encode_byte(input logic [7:0] b);
        logic [23:0] acc;
        acc = '0;
        for (int i = 0; i < 8; i++)
        begin
            acc[3*i +: 3] = b[i] ? SYM_ONE : SYM_ZERO;
        end
        return acc;
    endfunction

endpackage

[hw/rtl/lbg_ctrl.sv]
// Controller for the LED bar-graph renderer: sequences load, multiply,
// divide, setup and the per-LED run. Uses lbg_pkg for the ctl_t/sts_t structs.
module lbg_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  lbg_pkg::sts_t sts,
    output lbg_pkg::ctl_t ctl
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_SETUP = 3'd3;
    localparam logic [2:0] ST_RUN   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                ctl.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                ctl.div    = 1'b1;
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                ctl.setup  = 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                // An empty run ends without a transaction
                if (sts.run_empty)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctl.step = 1'b1;
                    if (sts.run_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

[hw/rtl/lbg_datapath.sv]
// Datapath for the LED bar-graph renderer: saturation, brightness and height
// products, reciprocal divide by 100, run setup and the LED index walker.
// Uses lbg_pkg for payload types, constants and helper functions.
module lbg_datapath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  lbg_pkg::cmd_t               command,
    input  logic [lbg_pkg::LED_W-1:0]   zero_end,
    input  logic [lbg_pkg::LED_W-1:0]   full_end,
    input  lbg_pkg::ctl_t               ctl,
    output lbg_pkg::sts_t               sts,
    output lbg_pkg::result_t            result
);

    localparam int LW  = lbg_pkg::LED_W;
    localparam int RW  = lbg_pkg::RUN_W;
    localparam int PW  = lbg_pkg::PCT_W;
    localparam int CPW = lbg_pkg::CPROD_W;
    localparam int HPW = lbg_pkg::HPROD_W;
    localparam int QW  = CPW + lbg_pkg::RECIP_W;

    // Captured command
    logic          op_reg;
    logic [PW-1:0] level_reg;
    logic [PW-1:0] bright_reg;
    logic [7:0]    red_reg;
    logic [7:0]    green_reg;
    logic [7:0]    blue_reg;
    logic [6:0]    size_reg;
    logic [LW-1:0] first_reg;
    logic [LW-1:0] span_reg;
    logic          down_reg;

    // Products
    logic [CPW-1:0] prod_red_reg;
    logic [CPW-1:0] prod_green_reg;
    logic [CPW-1:0] prod_blue_reg;
    logic [HPW-1:0] prod_height_reg;

    // Quotients
    logic [7:0]    scaled_red_reg;
    logic [7:0]    scaled_green_reg;
    logic [7:0]    scaled_blue_reg;
    logic [LW-1:0] height_reg;

    // Run
    logic [23:0]   enc_red_reg;
    logic [23:0]   enc_green_reg;
    logic [23:0]   enc_blue_reg;
    logic [LW-1:0] idx_reg;
    logic [RW-1:0] remain_reg;
    logic [RW-1:0] remain_next;
    logic [LW-1:0] idx_next;

    logic [QW-1:0] q_red;
    logic [QW-1:0] q_green;
    logic [QW-1:0] q_blue;
    logic [QW-1:0] q_height;
    logic [RW-1:0] room;
    logic [RW-1:0] marker_count;
    logic [LW-1:0] marker_start;

    // Capture the command and the bar geometry
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg     <= command.operation;
            level_reg  <= lbg_pkg::sat_pct(command.level_percent);
            bright_reg <= lbg_pkg::sat_pct(command.brightness_percent);
            red_reg    <= command.red_level;
            green_reg  <= command.green_level;
            blue_reg   <= command.blue_level;
            size_reg   <= command.marker_size;
            first_reg  <= zero_end;
            down_reg   <= (zero_end > full_end);
            span_reg   <= (zero_end > full_end) ? (zero_end - full_end)
                                                : (full_end - zero_end);
        end
    end

    // Form channel * brightness and level * span
    always_ff @(posedge clk)
    begin
        if (ctl.mul)
        begin
            prod_red_reg    <= CPW'(red_reg) * CPW'(bright_reg);
            prod_green_reg  <= CPW'(green_reg) * CPW'(bright_reg);
            prod_blue_reg   <= CPW'(blue_reg) * CPW'(bright_reg);
            prod_height_reg <= HPW'(level_reg) * HPW'(span_reg);
        end
    end

    // Divide by 100 through the reciprocal
    assign q_red    = QW'(prod_red_reg) * QW'(lbg_pkg::RECIP_100);
    assign q_green  = QW'(prod_green_reg) * QW'(lbg_pkg::RECIP_100);
    assign q_blue   = QW'(prod_blue_reg) * QW'(lbg_pkg::RECIP_100);
    assign q_height = QW'(prod_height_reg) * QW'(lbg_pkg::RECIP_100);

    always_ff @(posedge clk)
    begin
        if (ctl.div)
        begin
            scaled_red_reg   <= q_red[lbg_pkg::RECIP_SHIFT +: 8];
            scaled_green_reg <= q_green[lbg_pkg::RECIP_SHIFT +: 8];
            scaled_blue_reg  <= q_blue[lbg_pkg::RECIP_SHIFT +: 8];
            height_reg       <= q_height[lbg_pkg::RECIP_SHIFT +: LW];
        end
    end

    // Marker geometry: start at the level, stop at the last LED
    assign room         = RW'(span_reg) - RW'(height_reg) + RW'(1);
    assign marker_count = (size_reg < room) ? size_reg : room;
    assign marker_start = down_reg ? (first_reg - height_reg) : (first_reg + height_reg);

    // Encode the channels once per command
    always_ff @(posedge clk)
    begin
        if (ctl.setup)
        begin
            enc_red_reg   <= lbg_pkg::encode_byte(scaled_red_reg);
            enc_green_reg <= lbg_pkg::encode_byte(scaled_green_reg);
            enc_blue_reg  <= lbg_pkg::encode_byte(scaled_blue_reg);
        end
    end

    // Walk the LED index
    always_comb
    begin
        idx_next = idx_reg;
        if (ctl.setup)
        begin
            idx_next = (op_reg == lbg_pkg::OP_FILL) ? first_reg : marker_start;
        end
        else if (ctl.step)
        begin
            idx_next = down_reg ? (idx_reg - LW'(1)) : (idx_reg + LW'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
    end

    // Count the LEDs left in the run
    always_comb
    begin
        remain_next = remain_reg;
        if (ctl.setup)
        begin
            remain_next = (op_reg == lbg_pkg::OP_FILL) ? (RW'(height_reg) + RW'(1))
                                                       : marker_count;
        end
        else if (ctl.step)
        begin
            remain_next = remain_reg - RW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= '0;
        end
        else
        begin
            remain_reg <= remain_next;
        end
    end

    assign sts.run_empty = (remain_reg == '0);
    assign sts.run_last  = (remain_reg == RW'(1));

    assign result.led_index     = idx_reg;
    assign result.encoded_red   = enc_red_reg;
    assign result.encoded_green = enc_green_reg;
    assign result.encoded_blue  = enc_blue_reg;
    assign result.last_of_run   = sts.run_last;

endmodule

[hw/rtl/led_bar_graph_ws2812_renderer.sv]
// Top level of the LED bar-graph renderer: configuration registers plus the
// controller (lbg_ctrl) and datapath (lbg_datapath). Uses lbg_pkg.
//
//   Channel   Signals                          Transaction
//   command   start, busy, command             start high while busy low
//   result    strobe, result                   strobe high, one cycle each
//   config    cfg_we, cfg_index, cfg_data      cfg_we high
//
// A command runs through its setup steps (capture, multiply, divide, encode),
// then gives one result per cycle for each LED written, up to 64 LEDs.
// The run steps one LED per cycle through a single index walker.
// A command that writes no LED ends in the run state with no result.
// Reset clears the controller and the run counter; bar ends reset to
// 0 and LED_COUNT-1. The receiver cannot stall the result stream.
module led_bar_graph_ws2812_renderer
#(
    parameter int LED_COUNT = 64
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  lbg_pkg::cmd_t                     command,
    output logic                              strobe,
    output lbg_pkg::result_t                  result,
    input  logic                              cfg_we,
    input  logic [lbg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lbg_pkg::LED_W-1:0]         cfg_data
);

    localparam int LW = lbg_pkg::LED_W;
    localparam logic [LW-1:0] LED_MAX = LW'(LED_COUNT - 1);

    logic [LW-1:0] zero_end_reg;
    logic [LW-1:0] full_end_reg;
    logic [LW-1:0] cfg_clamped;
    lbg_pkg::ctl_t ctl;
    lbg_pkg::sts_t sts;

    // Clamp written ends to the strip
    assign cfg_clamped = (cfg_data > LED_MAX) ? LED_MAX : cfg_data;

    // Hold the bar ends
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_end_reg <= '0;
            full_end_reg <= LED_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lbg_pkg::CFG_FIRST_LED: zero_end_reg <= cfg_clamped;
                lbg_pkg::CFG_LAST_LED:  full_end_reg <= cfg_clamped;
                default:                ;
            endcase
        end
    end

    lbg_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    lbg_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .command  (command),
        .zero_end (zero_end_reg),
        .full_end (full_end_reg),
        .ctl      (ctl),
        .sts      (sts),
        .result   (result)
    );

    assign strobe = ctl.step;

endmodule

[sim/led_bar_graph_ws2812_renderer_tb.sv]
// Self-checking testbench for the LED bar-graph WS2812 renderer: directed and
// random bar commands, bar-end reconfiguration, per-LED write checking.
// Depends on lbg_pkg and led_bar_graph_ws2812_renderer from hw/rtl.
`timescale 1ns / 1ps

module led_bar_graph_ws2812_renderer_tb;

    localparam int STRIP_LEDS   = 64;
    localparam int LW           = lbg_pkg::LED_W;
    // Setup plus the longest run, with margin, before touching the registers
    localparam int DRAIN_CYCLES = 72;
    localparam int PHASE_ITEMS  = 50;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    lbg_pkg::cmd_t                 command;
    logic                          strobe;
    lbg_pkg::result_t              result;
    logic                          cfg_we;
    logic [lbg_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [LW-1:0]                 cfg_data;

    // Bar ends as the block should hold them
    logic [LW-1:0] bar_first;
    logic [LW-1:0] bar_last;

    // LED writes predicted but not yet seen
    lbg_pkg::result_t led_write_q[$];
    int               error_count;

    led_bar_graph_ws2812_renderer #(
        .LED_COUNT (STRIP_LEDS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .strobe    (strobe),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Expand a channel byte into WS2812 SPI symbols, bit i at [3i+2:3i]
    function automatic logic [23:0] spi_symbols(input logic [7:0] value);
        logic [23:0] bits;
        bits = '0;
        for (int i = 0; i < 8; i++)
        begin
            bits[3*i +: 3] = value[i] ? lbg_pkg::SYM_ONE : lbg_pkg::SYM_ZERO;
        end
        return bits;
    endfunction

    function automatic int unsigned percent_cap(input logic [7:0] value);
        return (value > 8'd100) ? 100 : int'(value);
    endfunction

    function automatic logic [LW-1:0] strip_clamp(input logic [LW-1:0] value);
        return (int'(value) > STRIP_LEDS - 1) ? LW'(STRIP_LEDS - 1) : value;
    endfunction

    // Queue the LED writes that one bar command produces
    task automatic predict_bar_writes(input lbg_pkg::cmd_t c);
        int unsigned      level;
        int unsigned      bright;
        int unsigned      span;
        int unsigned      height;
        int unsigned      zero_end;
        int unsigned      full_end;
        int unsigned      run_start;
        int unsigned      run_len;
        int unsigned      room;
        bit               descending;
        lbg_pkg::result_t w;
        level      = percent_cap(c.level_percent);
        bright     = percent_cap(c.brightness_percent);
        zero_end   = bar_first;
        full_end   = bar_last;
        descending = zero_end > full_end;
        span       = descending ? zero_end - full_end : full_end - zero_end;
        height     = level * span / 100;
        w.encoded_red   = spi_symbols(8'(int'(c.red_level) * bright / 100));
        w.encoded_green = spi_symbols(8'(int'(c.green_level) * bright / 100));
        w.encoded_blue  = spi_symbols(8'(int'(c.blue_level) * bright / 100));
        if (c.operation == lbg_pkg::OP_FILL)
        begin
            run_start = zero_end;
            run_len   = height + 1;
        end
        else
        begin
            run_start = descending ? zero_end - height : zero_end + height;
            room      = span - height + 1;
            run_len   = (c.marker_size < room) ? c.marker_size : room;
        end
        for (int unsigned k = 0; k < run_len; k++)
        begin
            w.led_index   = LW'(descending ? run_start - k : run_start + k);
            w.last_of_run = (k + 1 == run_len);
            led_write_q.push_back(w);
        end
    endtask

    function automatic lbg_pkg::cmd_t make_command(input logic op, input logic [7:0] level,
                                                   input logic [7:0] bright,
                                                   input logic [7:0] red,
                                                   input logic [7:0] green,
                                                   input logic [7:0] blue,
                                                   input logic [6:0] size);
        lbg_pkg::cmd_t c;
        c.operation          = op;
        c.level_percent      = level;
        c.brightness_percent = bright;
        c.red_level          = red;
        c.green_level        = green;
        c.blue_level         = blue;
        c.marker_size        = size;
        return c;
    endfunction

    function automatic lbg_pkg::cmd_t random_bar_command();
        lbg_pkg::cmd_t c;
        c.operation          = $urandom_range(0, 1) ? lbg_pkg::OP_MARKER : lbg_pkg::OP_FILL;
        c.level_percent      = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                            : 8'($urandom_range(0, 100));
        c.brightness_percent = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                            : 8'($urandom_range(0, 100));
        c.red_level          = 8'($urandom_range(0, 255));
        c.green_level        = 8'($urandom_range(0, 255));
        c.blue_level         = 8'($urandom_range(0, 255));
        c.marker_size        = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 64))
                                                          : 7'($urandom_range(0, 8));
        return c;
    endfunction

    // Send one bar command; start stays high so back-to-back commands need no gap
    task automatic send_command(input lbg_pkg::cmd_t c);
        int gap;
        gap = $urandom_range(0, 5);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start   <= 1'b1;
        command <= c;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        predict_bar_writes(c);
    endtask

    // Drop start, then hold until every LED write is in and the block is quiet
    task automatic drain_commands();
        @(negedge clk);
        start <= 1'b0;
        while (led_write_q.size() != 0 || busy)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [lbg_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [LW-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == lbg_pkg::CFG_FIRST_LED)
        begin
            bar_first = strip_clamp(value);
        end
        else if (idx == lbg_pkg::CFG_LAST_LED)
        begin
            bar_last = strip_clamp(value);
        end
    endtask

    task automatic set_bar_ends(input logic [LW-1:0] zero_end,
                                input logic [LW-1:0] full_end);
        drain_commands();
        write_register(lbg_pkg::CFG_FIRST_LED, zero_end);
        write_register(lbg_pkg::CFG_LAST_LED, full_end);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [23:0] expected,
                               input logic [23:0] actual);
        if (expected !== actual)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, expected, actual);
            error_count++;
        end
    endtask

    // Check every LED write transaction against the oldest prediction
    always @(posedge clk)
    begin
        lbg_pkg::result_t want;
        if (rst_n && strobe)
        begin
            if (led_write_q.size() == 0)
            begin
                $display("%0t: unexpected LED write, expected none, actual index %0d",
                         $time, result.led_index);
                error_count++;
            end
            else
            begin
                want = led_write_q.pop_front();
                check_field("led_index", 24'(want.led_index), 24'(result.led_index));
                check_field("encoded_red", want.encoded_red, result.encoded_red);
                check_field("encoded_green", want.encoded_green, result.encoded_green);
                check_field("encoded_blue", want.encoded_blue, result.encoded_blue);
                check_field("last_of_run", 24'(want.last_of_run), 24'(result.last_of_run));
            end
        end
    end

    // Reset ends: every operation, field extremes, marker clipping
    task automatic test_reset_ends();
        send_command(make_command(lbg_pkg::OP_FILL, 8'd0, 8'd100,
                                  8'hFF, 8'h00, 8'h80, 7'd0));
        send_command(make_command(lbg_pkg::OP_FILL, 8'd100, 8'd255,
                                  8'hFF, 8'hFF, 8'hFF, 7'd127));
        send_command(make_command(lbg_pkg::OP_FILL, 8'd255, 8'd0,
                                  8'hFF, 8'hFF, 8'hFF, 7'd0));
        send_command(make_command(lbg_pkg::OP_FILL, 8'd50, 8'd50,
                                  8'hAA, 8'h55, 8'h0F, 7'd0));
        send_command(make_command(lbg_pkg::OP_MARKER, 8'd0, 8'd100,
                                  8'h12, 8'h34, 8'h56, 7'd0));
        send_command(make_command(lbg_pkg::OP_MARKER, 8'd0, 8'd100,
                                  8'h55, 8'hAA, 8'hF0, 7'd1));
        send_command(make_command(lbg_pkg::OP_MARKER, 8'd100, 8'd100,
                                  8'h01, 8'h80, 8'h7F, 7'd64));
        send_command(make_command(lbg_pkg::OP_MARKER, 8'd37, 8'd99,
                                  8'hFE, 8'h01, 8'hC3, 7'd64));
        send_command(make_command(lbg_pkg::OP_MARKER, 8'd200, 8'd1,
                                  8'hFF, 8'hFF, 8'hFF, 7'd5));
    endtask

    // Equal ends: single-LED fill, marker clipped to one LED
    task automatic test_equal_ends();
        set_bar_ends(6'd20, 6'd20);
        send_command(make_command(lbg_pkg::OP_FILL, 8'd100, 8'd100,
                                  8'h3C, 8'hC3, 8'h99, 7'd0));
        send_command(make_command(lbg_pkg::OP_MARKER, 8'd50, 8'd75,
                                  8'hFF, 8'h10, 8'h01, 7'd64));
        send_command(make_command(lbg_pkg::OP_MARKER, 8'd50, 8'd75,
                                  8'hFF, 8'h10, 8'h01, 7'd0));
        set_bar_ends(6'd63, 6'd63);
        send_command(make_command(lbg_pkg::OP_FILL, 8'd255, 8'd255,
                                  8'h80, 8'h40, 8'h20, 7'd0));
        send_command(make_command(lbg_pkg::OP_MARKER, 8'd0, 8'd255,
                                  8'h08, 8'h04, 8'h02, 7'd2));
    endtask

    // Descending bar: walk indexes downward from first toward last
    task automatic test_descending_ends();
        set_bar_ends(6'd63, 6'd0);
        send_command(make_command(lbg_pkg::OP_FILL, 8'd100, 8'd100,
                                  8'hFF, 8'h00, 8'hFF, 7'd0));
        send_command(make_command(lbg_pkg::OP_FILL, 8'd10, 8'd60,
                                  8'h9A, 8'hBC, 8'hDE, 7'd0));
        send_command(make_command(lbg_pkg::OP_MARKER, 8'd30, 8'd100,
                                  8'h11, 8'h22, 8'h33, 7'd64));
        send_command(make_command(lbg_pkg::OP_MARKER, 8'd100, 8'd100,
                                  8'h44, 8'h55, 8'h66, 7'd3));
    endtask

    // Random commands over several bar settings, with random gaps between commands
    task automatic test_random_phases();
        int pick;
        logic [LW-1:0] zero_end;
        logic [LW-1:0] full_end;
        for (int phase = 0; phase < 4; phase++)
        begin
            pick     = $urandom_range(0, 3);
            zero_end = LW'($urandom_range(0, STRIP_LEDS - 1));
            full_end = LW'($urandom_range(0, STRIP_LEDS - 1));
            if (pick == 0)
            begin
                full_end = zero_end;
            end
            else if (pick == 1)
            begin
                zero_end = LW'(phase[0] ? STRIP_LEDS - 1 : 0);
                full_end = LW'(phase[0] ? 0 : STRIP_LEDS - 1);
            end
            set_bar_ends(zero_end, full_end);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_command(random_bar_command());
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        command     = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        error_count = 0;
        bar_first   = strip_clamp(6'd0);
        bar_last    = strip_clamp(6'd63);
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_ends();
        test_equal_ends();
        test_descending_ends();
        test_random_phases();

        drain_commands();
        if (error_count == 0)
        begin
            $display("led_bar_graph_ws2812_renderer test passed");
        end
        else
        begin
            $display("led_bar_graph_ws2812_renderer test failed");
        end
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2000000;
        $display("led_bar_graph_ws2812_renderer test failed");
        $finish;
    end

endmodule

[led_bar_graph_ws2812_renderer.f]
hw/rtl/lbg_pkg.sv
hw/rtl/lbg_ctrl.sv
hw/rtl/lbg_datapath.sv
hw/rtl/led_bar_graph_ws2812_renderer.sv
sim/led_bar_graph_ws2812_renderer_tb.sv
